@@ rtl/scdt_pkg.sv @@
// Package for the slotted countdown timer table.
// Types, field widths and defaults shared by the front end, back end and top; no dependencies.
package scdt_pkg;

  localparam int ID_SPACE     = 64;
  localparam int MAX_OUT      = 7;
  localparam int TIMERS_DEF   = 64;
  localparam int SLOTS_DEF    = 10;
  localparam int CMD_W        = 2;
  localparam int ID_W         = 6;
  localparam int TICKS_W      = 32;
  localparam int WALK_W       = ID_W + 1;
  localparam int CNT_W        = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_MOD  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               id_ok;
    logic [ID_W-1:0]    id;
    logic [TICKS_W-1:0] ticks;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CMD,
    B_RD,
    B_UPD,
    B_FIN
  } back_state_t;

endpackage

@@ rtl/scdt_ram.sv @@
// Generic simple dual-port RAM with registered read.
// Depends on nothing.
module scdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/scdt_front.sv @@
// Front end: accepts input transactions, classifies them, queues them.
// Depends on scdt_pkg.
module scdt_front
  import scdt_pkg::*;
#(
  parameter int NIDS = TIMERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [ID_W-1:0]    in_timer_id,
  input  logic [TICKS_W-1:0] in_ticks,
  output queue_out_t         q_out,
  input  logic               q_pop
);

  localparam logic [WALK_W-1:0] NIDS_L = WALK_W'(NIDS);

  item_t      mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  item_t      item_in;
  logic       push, pop;

  always_comb begin
    item_in.cmd   = cmd_t'(in_command);
    item_in.id_ok = {1'b0, in_timer_id} < NIDS_L;
    item_in.id    = in_timer_id;
    item_in.ticks = in_ticks;
  end

  assign in_ready    = (cnt_r != 2'd2);
  assign push        = in_valid && in_ready;
  assign pop         = q_pop && (cnt_r != 2'd0);
  assign q_out.valid = (cnt_r != 2'd0);
  assign q_out.item  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= item_in;
    end
  end

endmodule

@@ rtl/scdt_back.sv @@
// Back end: executes queued transactions against the timer table and
// drives the result register. Depends on scdt_pkg and scdt_ram.
module scdt_back
  import scdt_pkg::*;
#(
  parameter int NIDS  = TIMERS_DEF,
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  queue_out_t      q_out,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [ID_W-1:0] out_expired_id,
  output logic            out_expired,
  output logic            out_last
);

  localparam int AW = (NIDS > 1) ? $clog2(NIDS) : 1;
  localparam int BW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [WALK_W-1:0] NIDS_L  = WALK_W'(NIDS);
  localparam logic [WALK_W-1:0] SLOTS_L = WALK_W'(SLOTS);
  localparam logic [BW-1:0]     BLAST   = BW'(SLOTS - 1);
  localparam logic [CNT_W-1:0]  MAXO    = CNT_W'(MAX_OUT);

  back_state_t        state_r, state_nxt;
  item_t              item_r;
  logic [WALK_W-1:0]  id_r;
  logic [CNT_W-1:0]   n_r;
  logic               pend_v_r;
  logic [ID_W-1:0]    pend_id_r;
  logic [BW-1:0]      bucket_r;
  logic [NIDS-1:0]    armed_r;
  logic               armed_rd_r;
  logic               out_valid_r, out_exp_r, out_last_r;
  logic [ID_W-1:0]    out_id_r;

  logic               slot_free;
  logic               emit, emit_exp, emit_last;
  logic [ID_W-1:0]    emit_id;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [TICKS_W-1:0] ram_wdata, ram_rdata;
  logic               hit, expire, stall;
  logic [WALK_W-1:0]  id_step, start_id;

  scdt_ram #(.WIDTH(TICKS_W), .DEPTH(NIDS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (id_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign hit       = armed_rd_r && (ram_rdata != '0);
  assign expire    = hit && (ram_rdata == TICKS_W'(1)) && (n_r < MAXO);
  assign stall     = expire && pend_v_r && !slot_free;
  assign id_step   = id_r + SLOTS_L;
  assign start_id  = WALK_W'(bucket_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_out.valid) begin
          if (q_out.item.cmd == CMD_TICK) begin
            state_nxt = (start_id < NIDS_L) ? B_RD : B_FIN;
          end else begin
            state_nxt = B_CMD;
          end
        end
      end
      B_CMD: begin
        if (slot_free) begin
          state_nxt = B_IDLE;
        end
      end
      B_RD: state_nxt = B_UPD;
      B_UPD: begin
        if (!stall) begin
          state_nxt = (id_step < NIDS_L) ? B_RD : B_FIN;
        end
      end
      B_FIN: begin
        if (slot_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_id   = '0;
    emit_exp  = 1'b0;
    emit_last = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = id_r[AW-1:0];
    ram_wdata = ram_rdata - TICKS_W'(1);
    unique case (state_r)
      B_IDLE: q_pop = q_out.valid;
      B_CMD: begin
        ram_waddr = item_r.id[AW-1:0];
        ram_wdata = item_r.ticks;
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          ram_we    = item_r.id_ok &&
                      (item_r.cmd == CMD_ADD || item_r.cmd == CMD_MOD);
        end
      end
      B_RD: ram_re = 1'b1;
      B_UPD: begin
        if (!stall) begin
          ram_we = hit;
          if (expire && pend_v_r) begin
            emit     = 1'b1;
            emit_id  = pend_id_r;
            emit_exp = 1'b1;
          end
        end
      end
      B_FIN: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_id   = pend_v_r ? pend_id_r : '0;
          emit_exp  = pend_v_r;
          emit_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      bucket_r    <= '0;
      armed_r     <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          pend_v_r <= 1'b0;
          n_r      <= '0;
        end
        B_CMD: begin
          if (slot_free && item_r.id_ok) begin
            if (item_r.cmd == CMD_ADD) begin
              armed_r[item_r.id[AW-1:0]] <= 1'b1;
            end else if (item_r.cmd == CMD_DEL) begin
              armed_r[item_r.id[AW-1:0]] <= 1'b0;
            end
          end
        end
        B_UPD: begin
          if (!stall && expire) begin
            pend_v_r <= 1'b1;
            n_r      <= n_r + CNT_W'(1);
          end
        end
        B_FIN: begin
          if (slot_free) begin
            bucket_r <= (bucket_r == BLAST) ? '0 : bucket_r + BW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_id_r   <= emit_id;
      out_exp_r  <= emit_exp;
      out_last_r <= emit_last;
    end
    if (state_r == B_IDLE && q_out.valid) begin
      item_r <= q_out.item;
      id_r   <= start_id;
    end
    if (state_r == B_RD) begin
      armed_rd_r <= armed_r[id_r[AW-1:0]];
    end
    if (state_r == B_UPD && !stall) begin
      id_r <= id_step;
      if (expire) begin
        pend_id_r <= id_r[ID_W-1:0];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_expired_id = out_id_r;
  assign out_expired    = out_exp_r;
  assign out_last       = out_last_r;

endmodule

@@ rtl/slotted_countdown_timer_table.sv @@
// Slotted countdown timer table. Tick: RAM read-modify-write of the count
// for each timer of the current bucket. The input queue (2 deep) keeps
// accepting while the back end works. Reset clears the queue, armed flags
// and bucket pointer; counts stay undefined until written. Depends on
// scdt_pkg, scdt_front, scdt_back.
module slotted_countdown_timer_table
  import scdt_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEF,
  parameter int SLOTS  = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [ID_W-1:0]    in_timer_id,
  input  logic [TICKS_W-1:0] in_ticks,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    out_expired_id,
  output logic               out_expired,
  output logic               out_last
);

  localparam int NIDS = (TIMERS < ID_SPACE) ? TIMERS : ID_SPACE;

  queue_out_t q_out;
  logic       q_pop;

  scdt_front #(.NIDS(NIDS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_timer_id (in_timer_id),
    .in_ticks    (in_ticks),
    .q_out       (q_out),
    .q_pop       (q_pop)
  );

  scdt_back #(.NIDS(NIDS), .SLOTS(SLOTS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_out          (q_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_expired_id (out_expired_id),
    .out_expired    (out_expired),
    .out_last       (out_last)
  );

endmodule

@@ tb/slotted_countdown_timer_table_tb.sv @@
// Testbench for slotted_countdown_timer_table: directed and random commands,
// checked against a cycle-free timer table predictor. Depends on scdt_pkg and
// the rtl top; valid/ready on both channels with random idling and stalls.
module slotted_countdown_timer_table_tb;
  import scdt_pkg::*;

  localparam int N_TIMERS     = TIMERS_DEF;
  localparam int N_SLOTS      = SLOTS_DEF;
  localparam int RANDOM_ITEMS = 300;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int IDLE_LIMIT   = 5000;

  typedef struct {
    cmd_t               cmd;
    logic [ID_W-1:0]    id;
    logic [TICKS_W-1:0] ticks;
  } timer_cmd_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic            expired;
    logic            last;
  } report_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   in_command = '0;
  logic [ID_W-1:0]    in_timer_id = '0;
  logic [TICKS_W-1:0] in_ticks = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ID_W-1:0]    out_expired_id;
  logic               out_expired;
  logic               out_last;

  timer_cmd_t command_fifo[$];
  report_t    pending_reports[$];

  bit                 armed_tbl[ID_SPACE];
  logic [TICKS_W-1:0] count_tbl[ID_SPACE];
  int unsigned        cur_bucket;

  int mismatches = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_left = 0;
  int reports_seen = 0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;

  slotted_countdown_timer_table uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_timer_id(in_timer_id),
    .in_ticks(in_ticks),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_expired_id(out_expired_id),
    .out_expired(out_expired),
    .out_last(out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic report_t make_report(logic [ID_W-1:0] id, logic expired, logic last);
    report_t r;
    r.id = id;
    r.expired = expired;
    r.last = last;
    return r;
  endfunction

  // Applies one accepted transaction to the timer table and queues its reports.
  task automatic advance_timer_table(cmd_t cmd, logic [ID_W-1:0] id,
                                     logic [TICKS_W-1:0] ticks);
    report_t hits[$];
    bit id_ok;
    id_ok = (int'(id) < N_TIMERS) && (int'(id) < ID_SPACE);
    if (cmd == CMD_TICK) begin
      for (int i = 0; i < ID_SPACE && i < N_TIMERS; i++) begin
        if (armed_tbl[i] && (i % N_SLOTS) == cur_bucket && count_tbl[i] != '0) begin
          count_tbl[i] = count_tbl[i] - 1;
          if (count_tbl[i] == '0 && hits.size() < MAX_OUT)
            hits.push_back(make_report(ID_W'(i), 1'b1, 1'b0));
        end
      end
      cur_bucket = (cur_bucket + 1 < N_SLOTS) ? cur_bucket + 1 : 0;
      if (hits.size() == 0) begin
        pending_reports.push_back(make_report('0, 1'b0, 1'b1));
      end else begin
        hits[hits.size()-1].last = 1'b1;
        foreach (hits[k]) pending_reports.push_back(hits[k]);
      end
    end else begin
      if (id_ok) begin
        case (cmd)
          CMD_ADD: begin
            armed_tbl[id] = 1'b1;
            count_tbl[id] = ticks;
          end
          CMD_DEL: armed_tbl[id] = 1'b0;
          default: count_tbl[id] = ticks;
        endcase
      end
      pending_reports.push_back(make_report('0, 1'b0, 1'b1));
    end
  endtask

  task automatic queue_cmd(cmd_t cmd, int id, logic [TICKS_W-1:0] ticks);
    timer_cmd_t c;
    c.cmd = cmd;
    c.id = ID_W'(id);
    c.ticks = ticks;
    command_fifo.push_back(c);
  endtask

  // driver
  always @(posedge clk) begin : drv
    timer_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready)
        advance_timer_table(cmd_t'(in_command), in_timer_id, in_ticks);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (command_fifo.size() > 0) begin
          c = command_fifo.pop_front();
          in_command <= c.cmd;
          in_timer_id <= c.id;
          in_ticks <= c.ticks;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
            gap_left <= 0;
          end else begin
            if ($urandom_range(0, 99) < 3) burst_left <= $urandom_range(20, 60);
            gap_left <= pick_gap();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver back-pressure
  always @(posedge clk) begin : mon
    report_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        reports_seen = reports_seen + 1;
        if (pending_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction id=%0d expired=%0b last=%0b",
                   $time, out_expired_id, out_expired, out_last);
        end else begin
          want = pending_reports.pop_front();
          if (out_expired_id !== want.id) begin
            mismatches++;
            $display("%0t: expired_id expected %0d actual %0d", $time, want.id, out_expired_id);
          end
          if (out_expired !== want.expired) begin
            mismatches++;
            $display("%0t: expired expected %0b actual %0b", $time, want.expired, out_expired);
          end
          if (out_last !== want.last) begin
            mismatches++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
          end
        end
      end
      if (!hold_done && reports_seen >= HOLD_AT) begin
        hold_done <= 1'b1;
        out_ready <= 1'b0;
        stall_left <= HOLD_CYCLES;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 20) stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stim
    int r;
    logic [TICKS_W-1:0] cnt;
    cmd_t cmd;
    foreach (armed_tbl[i]) begin
      armed_tbl[i] = 1'b0;
      count_tbl[i] = '0;
    end
    cur_bucket = 0;

    // full bucket 0 expiring on one tick
    for (int i = 0; i < ID_SPACE; i += N_SLOTS) queue_cmd(CMD_ADD, i, 1);
    queue_cmd(CMD_TICK, 0, 0);
    queue_cmd(CMD_ADD, 63, '1);
    queue_cmd(CMD_ADD, 1, 0);          // never expires
    queue_cmd(CMD_ADD, 11, 1);
    queue_cmd(CMD_ADD, 11, 2);         // re-arm
    queue_cmd(CMD_MOD, 21, 1);         // disarmed stays disarmed
    queue_cmd(CMD_DEL, 7, 0);          // delete of disarmed timer
    queue_cmd(CMD_ADD, 41, 3);
    queue_cmd(CMD_MOD, 41, 1);
    queue_cmd(CMD_TICK, 0, 0);
    queue_cmd(CMD_DEL, 63, '1);
    queue_cmd(CMD_TICK, 0, 0);
    queue_cmd(CMD_TICK, 0, 0);
    queue_cmd(CMD_TICK, 0, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50) cmd = CMD_TICK;
      else if (r < 78) cmd = CMD_ADD;
      else if (r < 88) cmd = CMD_DEL;
      else cmd = CMD_MOD;
      r = $urandom_range(0, 99);
      if (r < 10) cnt = '0;
      else if (r < 85) cnt = $urandom_range(1, 3);
      else cnt = $urandom;
      queue_cmd(cmd, $urandom_range(0, 63), cnt);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (command_fifo.size() > 0 || in_valid || pending_reports.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_reports.size() > 0)
      $display("%0t: %0d expected transactions never arrived", $time, pending_reports.size());
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
